@@ src/ufd_pkg.sv @@
// Shared types and constants of the UTF-8 stream decoder.
package ufd_pkg;

   localparam int BYTE_W = 8;
   localparam int CP_W   = 21;

   localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;

   localparam logic [1:0] PUSH_NONE = 2'd0;
   localparam logic [1:0] PUSH_ONE  = 2'd1;
   localparam logic [1:0] PUSH_TWO  = 2'd2;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            bad_sequence;
      logic            last_of_run;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

@@ src/ufd_channel_if.sv @@
// Valid/ready channel interfaces for the byte input and the code point output.
interface ufd_req_if;
   logic                     valid;
   logic                     ready;
   logic [ufd_pkg::BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface ufd_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [ufd_pkg::CP_W-1:0] code_point;
   logic                     bad_sequence;
   logic                     last_of_run;

   modport source (output valid, output code_point, output bad_sequence,
                   output last_of_run, input ready);
   modport sink (input valid, input code_point, input bad_sequence,
                 input last_of_run, output ready);
endinterface

@@ src/ufd_front.sv @@
// Front end: accepts bytes, tracks the open sequence and produces zero to two results.
module ufd_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [ufd_pkg::BYTE_W-1:0] data_byte,
   output ufd_pkg::push_type          push
);

   typedef struct packed {
      logic                     emit;
      ufd_pkg::result_type      res;
      logic [1:0]               pending;
      logic [ufd_pkg::CP_W-1:0] partial;
   } lead_type;

   function automatic lead_type decode_lead(input logic [ufd_pkg::BYTE_W-1:0] b);
      lead_type l;
      l.emit             = 1'b1;
      l.res.code_point   = ufd_pkg::REPLACEMENT;
      l.res.bad_sequence = 1'b1;
      l.res.last_of_run  = 1'b1;
      l.pending          = 2'd0;
      l.partial          = '0;
      if (b[7] == 1'b0) begin
         l.res.code_point   = {{(ufd_pkg::CP_W-ufd_pkg::BYTE_W){1'b0}}, b};
         l.res.bad_sequence = 1'b0;
      end else if (b[7:5] == 3'b110) begin
         l.emit    = 1'b0;
         l.pending = 2'd1;
         l.partial = {{(ufd_pkg::CP_W-5){1'b0}}, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
         l.emit    = 1'b0;
         l.pending = 2'd2;
         l.partial = {{(ufd_pkg::CP_W-4){1'b0}}, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
         l.emit    = 1'b0;
         l.pending = 2'd3;
         l.partial = {{(ufd_pkg::CP_W-3){1'b0}}, b[2:0]};
      end
      return l;
   endfunction

   logic [1:0]               pending_ff, pending_in;
   logic [ufd_pkg::CP_W-1:0] partial_ff, partial_in;
   lead_type                 lead;
   logic                     is_cont;
   logic [ufd_pkg::CP_W-1:0] joined;

   always_comb begin
      lead    = decode_lead(data_byte);
      is_cont = (data_byte[7:6] == 2'b10);
      joined  = {partial_ff[ufd_pkg::CP_W-7:0], data_byte[5:0]};

      pending_in = pending_ff;
      partial_in = partial_ff;
      push.count = ufd_pkg::PUSH_NONE;
      push.first = lead.res;
      push.second = lead.res;

      if (accept) begin
         if (pending_ff != 2'd0) begin
            if (is_cont) begin
               pending_in = pending_ff - 2'd1;
               partial_in = joined;
               if (pending_ff == 2'd1) begin
                  push.count             = ufd_pkg::PUSH_ONE;
                  push.first.code_point   = joined;
                  push.first.bad_sequence = 1'b0;
                  push.first.last_of_run  = 1'b1;
                  partial_in             = '0;
               end
            end else begin
               push.first.code_point   = ufd_pkg::REPLACEMENT;
               push.first.bad_sequence = 1'b1;
               push.first.last_of_run  = !lead.emit;
               push.count = lead.emit ? ufd_pkg::PUSH_TWO : ufd_pkg::PUSH_ONE;
               pending_in = lead.pending;
               partial_in = lead.partial;
            end
         end else begin
            push.count = lead.emit ? ufd_pkg::PUSH_ONE : ufd_pkg::PUSH_NONE;
            pending_in = lead.pending;
            partial_in = lead.partial;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
         partial_ff <= '0;
      end else begin
         pending_ff <= pending_in;
         partial_ff <= partial_in;
      end
   end

   a_two_starts_bad: assert property (@(posedge clock) disable iff (reset)
      push.count == ufd_pkg::PUSH_TWO |-> push.first.bad_sequence && !push.first.last_of_run)
      else $error("double result must open with a replacement");

   a_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      !accept |-> push.count == ufd_pkg::PUSH_NONE)
      else $error("result pushed without a transaction");

   a_open_after_lead: assert property (@(posedge clock) disable iff (reset)
      accept && pending_ff == 2'd0 && data_byte[7:6] == 2'b11 && data_byte[7:3] != 5'b11111
      |=> pending_ff != 2'd0)
      else $error("valid lead did not open a sequence");

endmodule

@@ src/ufd_queue.sv @@
// Result queue: takes up to two results per cycle from the front, hands one per cycle on.
module ufd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  ufd_pkg::push_type   push,
   output logic                has_room,
   input  logic                pop,
   output logic                not_empty,
   output ufd_pkg::result_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
   endfunction

   ufd_pkg::result_type mem [DEPTH];
   logic [PTR_W-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign has_room  = (count_ff <= ROOM_MAX);
   assign not_empty = (count_ff != '0);
   assign head      = mem[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      case (push.count)
         ufd_pkg::PUSH_ONE: wr_in = next_ptr(wr_ff);
         ufd_pkg::PUSH_TWO: wr_in = next_ptr(next_ptr(wr_ff));
         default:           wr_in = wr_ff;
      endcase
      rd_in    = pop ? next_ptr(rd_ff) : rd_ff;
      count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != ufd_pkg::PUSH_NONE) begin
         mem[wr_ff] <= push.first;
      end
      if (push.count == ufd_pkg::PUSH_TWO) begin
         mem[next_ptr(wr_ff)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push.count != ufd_pkg::PUSH_NONE |-> has_room)
      else $error("push without room");

endmodule

@@ src/ufd_back.sv @@
// Back end: output register that drains the queue onto the result channel.
module ufd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                not_empty,
   input  ufd_pkg::result_type head,
   output logic                pop,
   ufd_rsp_if.source           rsp
);

   logic                valid_ff, valid_in;
   ufd_pkg::result_type data_ff, data_in;

   always_comb begin
      pop      = not_empty && (!valid_ff || rsp.ready);
      valid_in = pop || (valid_ff && !rsp.ready);
      data_in  = pop ? head : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp.valid        = valid_ff;
   assign rsp.code_point   = data_ff.code_point;
   assign rsp.bad_sequence = data_ff.bad_sequence;
   assign rsp.last_of_run  = data_ff.last_of_run;

endmodule

@@ src/utf8_stream_decoder.sv @@
// Top level of the UTF-8 stream decoder: front end, result queue and output register.
// A byte is taken whenever the result queue has two free slots, so bytes stream
// at one per cycle while the queue has room; the output register delivers one
// code point per cycle while the receiver is ready, so a byte that yields two
// results (an interrupted sequence followed by a byte that itself produces a result)
// needs an extra output slot, absorbed by the DEPTH-entry queue.
module utf8_stream_decoder #(
   parameter int DEPTH = 4
) (
   input logic       clock,
   input logic       reset,
   ufd_req_if.sink   req_chan,
   ufd_rsp_if.source rsp_chan
);

   ufd_pkg::push_type   push;
   ufd_pkg::result_type head;
   logic                has_room;
   logic                not_empty;
   logic                pop;
   logic                accept;

   assign req_chan.ready = has_room;
   assign accept         = req_chan.valid && has_room;

   ufd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_chan.data_byte),
      .push      (push)
   );

   ufd_queue #(.DEPTH(DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (has_room),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   ufd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop),
      .rsp       (rsp_chan)
   );

endmodule

@@ verif/utf8_stream_decoder_test.sv @@
// Self-checking testbench for the UTF-8 stream decoder with a code point scoreboard.
module utf8_stream_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] CONT_LO  = 8'h80;
   localparam logic [7:0] CONT_HI  = 8'hBF;
   localparam logic [7:0] LEAD2_LO = 8'hC0;
   localparam logic [7:0] LEAD3_LO = 8'hE0;
   localparam logic [7:0] LEAD4_LO = 8'hF0;
   localparam logic [7:0] LEAD4_HI = 8'hF7;
   localparam int RANDOM_BYTES = 1050;
   localparam int CYCLE_LIMIT  = 400000;

   class code_point_board;
      ufd_pkg::result_type     due_q[$];
      logic [1:0]              open_count;
      logic [ufd_pkg::CP_W-1:0] partial;
      int errors;
      int bytes_noted;
      int points_checked;
      int replacements;
      int double_bytes;

      function new();
         open_count = '0;
         partial = '0;
      endfunction

      function void add_point(logic [ufd_pkg::CP_W-1:0] cp, logic bad);
         ufd_pkg::result_type r;
         r.code_point = cp;
         r.bad_sequence = bad;
         r.last_of_run = 1'b0;
         due_q.push_back(r);
      endfunction

      function void take_lead(logic [7:0] b);
         if (b < CONT_LO) begin
            add_point({13'd0, b}, 1'b0);
         end else if (b <= CONT_HI) begin
            add_point(ufd_pkg::REPLACEMENT, 1'b1);
         end else if (b < LEAD3_LO) begin
            partial = {16'd0, b[4:0]};
            open_count = 2'd1;
         end else if (b < LEAD4_LO) begin
            partial = {17'd0, b[3:0]};
            open_count = 2'd2;
         end else if (b <= LEAD4_HI) begin
            partial = {18'd0, b[2:0]};
            open_count = 2'd3;
         end else begin
            add_point(ufd_pkg::REPLACEMENT, 1'b1);
         end
      endfunction

      function void note_byte(logic [7:0] b);
         int prior;
         ufd_pkg::result_type r;
         prior = due_q.size();
         bytes_noted++;
         if (open_count != 0) begin
            if (b >= CONT_LO && b <= CONT_HI) begin
               partial = {partial[ufd_pkg::CP_W-7:0], b[5:0]};
               open_count = open_count - 2'd1;
               if (open_count == 0) begin
                  add_point(partial, 1'b0);
                  partial = '0;
               end
            end else begin
               add_point(ufd_pkg::REPLACEMENT, 1'b1);
               open_count = '0;
               partial = '0;
               take_lead(b);
            end
         end else begin
            take_lead(b);
         end
         if (due_q.size() > prior) begin
            r = due_q.pop_back();
            r.last_of_run = 1'b1;
            due_q.push_back(r);
         end
         if (due_q.size() - prior == 2) double_bytes++;
      endfunction

      function void check_point(ufd_pkg::result_type got);
         ufd_pkg::result_type want;
         if (due_q.size() == 0) begin
            $error("unexpected code point %h (bad %b, last %b)",
                   got.code_point, got.bad_sequence, got.last_of_run);
            errors++;
            return;
         end
         want = due_q.pop_front();
         points_checked++;
         if (want.bad_sequence) replacements++;
         if (got.code_point !== want.code_point) begin
            $error("code_point: expected %h, got %h", want.code_point, got.code_point);
            errors++;
         end
         if (got.bad_sequence !== want.bad_sequence) begin
            $error("bad_sequence: expected %b, got %b", want.bad_sequence, got.bad_sequence);
            errors++;
         end
         if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %b, got %b", want.last_of_run, got.last_of_run);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   send_gap_max = 0;
   int   recv_gap_max = 0;
   int   rsp_hold = 0;

   code_point_board board = new();

   ufd_req_if req_bus();
   ufd_rsp_if rsp_bus();

   utf8_stream_decoder uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      board.note_byte(b);
   endtask

   function automatic logic [7:0] lead_for(int len);
      case (len)
         2: return 8'($urandom_range(LEAD2_LO, LEAD3_LO - 1));
         3: return 8'($urandom_range(LEAD3_LO, LEAD4_LO - 1));
         default: return 8'($urandom_range(LEAD4_LO, LEAD4_HI));
      endcase
   endfunction

   task automatic send_random_char();
      int pick;
      int len;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 22) begin
         len = $urandom_range(2, 4);
         send_byte(lead_for(len));
         repeat ($urandom_range(0, len - 2))
            send_byte(8'($urandom_range(CONT_LO, CONT_HI)));
         if ($urandom_range(0, 1)) send_byte(8'($urandom_range(0, CONT_LO - 1)));
         else send_byte(8'($urandom_range(LEAD2_LO, 255)));
      end else begin
         len = (pick < 40) ? 1 : (pick < 60) ? 2 : (pick < 80) ? 3 : 4;
         if (len == 1) begin
            send_byte(8'($urandom_range(0, CONT_LO - 1)));
         end else begin
            send_byte(lead_for(len));
            repeat (len - 1) send_byte(8'($urandom_range(CONT_LO, CONT_HI)));
         end
      end
   endtask

   task automatic drain_points();
      while (board.due_q.size() != 0) @(posedge clock);
   endtask

   task automatic receive_points();
      int stall;
      ufd_pkg::result_type got;
      forever begin
         if (rsp_hold > 0) begin
            stall = rsp_hold;
            rsp_hold = 0;
         end else begin
            stall = $urandom_range(0, recv_gap_max);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.code_point = rsp_bus.code_point;
         got.bad_sequence = rsp_bus.bad_sequence;
         got.last_of_run = rsp_bus.last_of_run;
         board.check_point(got);
      end
   endtask

   initial begin
      logic [7:0] directed[$];
      directed = '{8'h00, 8'h7F, 8'h80, 8'hBF, 8'hF8, 8'hFF,
                   8'hC2, 8'hA9, 8'hDF, 8'hBF,
                   8'hEF, 8'hBF, 8'hBF,
                   8'hF7, 8'hBF, 8'hBF, 8'hBF,
                   8'hE2, 8'h82, 8'h41,
                   8'hC3, 8'hC3, 8'hA9,
                   8'hE1, 8'hFF};
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.data_byte <= '0;
      rsp_bus.ready <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      fork
         receive_points();
      join_none

      foreach (directed[i]) send_byte(directed[i]);
      send_byte(8'hF0);
      send_byte(8'h90);
      send_byte(8'h80);
      send_byte(8'h80);

      // hold the output for a long stretch while bytes are offered, filling the queue
      rsp_hold = 300;
      repeat (30) send_random_char();
      req_bus.valid <= 1'b0;
      drain_points();

      while (board.bytes_noted < RANDOM_BYTES) begin
         if (board.bytes_noted % 100 < 5) begin
            send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
            recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
         end
         send_random_char();
      end
      req_bus.valid <= 1'b0;

      drain_points();
      repeat (10) @(posedge clock);
      if (board.due_q.size() != 0) begin
         $error("%0d code points never arrived", board.due_q.size());
         board.errors++;
      end
      $display("tb: %0d bytes decoded into %0d code points", board.bytes_noted,
               board.points_checked);
      $display("tb: %0d replacements, %0d bytes with two results", board.replacements,
               board.double_bytes);
      if (board.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
